// ===== rtl/aspb_pkg.sv =====
// ----------------------------------------------------------------------------
// aspb_pkg
// Shared types and constants for the anti-aliased segment pixel blend.
// ----------------------------------------------------------------------------
package aspb_pkg;

  // Result bits of the distance root, and the saturated distance
  localparam int unsigned ROOT_BITS = 13;
  localparam logic [ROOT_BITS-1:0] DIST_CAP = 13'h1FFF;

  // Accumulator width of the root cells
  localparam int unsigned ACC_W = 66;

  // Fields that ride along with the geometry
  typedef struct packed {
    logic [11:0] radius;
    logic [23:0] color;
    logic [31:0] dest;
  } side_t;

  // Data handed from cell to cell of the root chain
  typedef struct packed {
    logic [ROOT_BITS-1:0] n;    // root bits settled so far
    logic [ACC_W-1:0]     s;    // n*n*den
    logic [ACC_W-1:0]     t;    // n*den
    logic [ACC_W-1:0]     num;  // radicand numerator
    logic [ACC_W-1:0]     den;  // radicand denominator
    logic                 cap;  // distance saturates
    side_t                side;
  } cell_t;

endpackage

// ===== rtl/aspb_geom.sv =====
// ----------------------------------------------------------------------------
// aspb_geom
// Five-stage front end: half-pixel vectors, products, dot and cross sums,
// region choice, and the radicand numerator and denominator for the root.
// ----------------------------------------------------------------------------
module aspb_geom #(
  parameter int unsigned PIXEL_COORD_BITS = 12,
  parameter int unsigned RADIUS_FRAC_BITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [11:0]       pixel_x_i,
  input  logic [11:0]       pixel_y_i,
  input  logic [15:0]       start_x_i,
  input  logic [15:0]       start_y_i,
  input  logic [15:0]       end_x_i,
  input  logic [15:0]       end_y_i,
  input  aspb_pkg::side_t   side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output aspb_pkg::cell_t   cell_o
);
  import aspb_pkg::*;

  localparam int unsigned SC = 2 * RADIUS_FRAC_BITS - 2;
  localparam logic [39:0] AC_LIMIT = 40'd1 << (32 - RADIUS_FRAC_BITS);

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  // Stall chain: a stage loads when empty or when its successor loads
  assign rdy_e   = !ve_q || ready_i;
  assign rdy_d   = !vd_q || rdy_e;
  assign rdy_c   = !vc_q || rdy_d;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = ve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= vd_q;
    end
  end

  // Stage A: vectors in half-pixel units
  logic [11:0] xm, ym;
  logic signed [18:0] px, py, ax, ay, bx, by;
  logic signed [18:0] vx_q, vy_q, wx_q, wy_q, dx_q, dy_q;
  side_t side_a_q, side_b_q, side_c_q, side_d_q;

  always_comb begin
    xm = '0;
    ym = '0;
    for (int i = 0; i < 12; i++) begin
      if (i < PIXEL_COORD_BITS) begin
        xm[i] = pixel_x_i[i];
        ym[i] = pixel_y_i[i];
      end
    end
  end

  assign px = signed'({6'd0, xm, 1'b1});
  assign py = signed'({6'd0, ym, 1'b1});
  assign ax = signed'({{2{start_x_i[15]}}, start_x_i, 1'b0});
  assign ay = signed'({{2{start_y_i[15]}}, start_y_i, 1'b0});
  assign bx = signed'({{2{end_x_i[15]}}, end_x_i, 1'b0});
  assign by = signed'({{2{end_y_i[15]}}, end_y_i, 1'b0});

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      vx_q     <= bx - ax;
      vy_q     <= by - ay;
      wx_q     <= px - ax;
      wy_q     <= py - ay;
      dx_q     <= px - bx;
      dy_q     <= py - by;
      side_a_q <= side_i;
    end
  end

  // Stage B: products
  logic signed [37:0] p_vxwx_q, p_vywy_q, p_vxvx_q, p_vyvy_q, p_vxwy_q, p_vywx_q;
  logic signed [37:0] p_wxwx_q, p_wywy_q, p_dxdx_q, p_dydy_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      p_vxwx_q <= vx_q * wx_q;
      p_vywy_q <= vy_q * wy_q;
      p_vxvx_q <= vx_q * vx_q;
      p_vyvy_q <= vy_q * vy_q;
      p_vxwy_q <= vx_q * wy_q;
      p_vywx_q <= vy_q * wx_q;
      p_wxwx_q <= wx_q * wx_q;
      p_wywy_q <= wy_q * wy_q;
      p_dxdx_q <= dx_q * dx_q;
      p_dydy_q <= dy_q * dy_q;
      side_b_q <= side_a_q;
    end
  end

  // Stage C: dot, length, cross and endpoint distances squared
  logic signed [39:0] c1_q, c2_q, cr_q, e1_q, e2_q;

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      c1_q     <= 40'(p_vxwx_q) + 40'(p_vywy_q);
      c2_q     <= 40'(p_vxvx_q) + 40'(p_vyvy_q);
      cr_q     <= 40'(p_vxwy_q) - 40'(p_vywx_q);
      e1_q     <= 40'(p_wxwx_q) + 40'(p_wywy_q);
      e2_q     <= 40'(p_dxdx_q) + 40'(p_dydy_q);
      side_c_q <= side_b_q;
    end
  end

  // Stage D: pick the nearest region of the capsule
  logic        line_q, cap_q;
  logic [36:0] dh2_q;
  logic [29:0] ac_q;
  logic [36:0] c2l_q;
  logic [39:0] ac_full;

  assign ac_full = cr_q[39] ? 40'(-cr_q) : 40'(cr_q);

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      c2l_q    <= c2_q[36:0];
      ac_q     <= ac_full[29:0];
      side_d_q <= side_c_q;
      if (c1_q <= 40'sd0) begin
        line_q <= 1'b0;
        cap_q  <= 1'b0;
        dh2_q  <= e1_q[36:0];
      end else if (c2_q <= c1_q) begin
        line_q <= 1'b0;
        cap_q  <= 1'b0;
        dh2_q  <= e2_q[36:0];
      end else begin
        line_q <= 1'b1;
        cap_q  <= (ac_full >= AC_LIMIT);
        dh2_q  <= e1_q[36:0];
      end
    end
  end

  // Stage E: radicand for the root chain
  logic [59:0] sq;
  cell_t       cell_q;

  assign sq = ac_q * ac_q;

  always_ff @(posedge clk_i) begin
    if (rdy_e && vd_q) begin
      cell_q.n    <= '0;
      cell_q.s    <= '0;
      cell_q.t    <= '0;
      cell_q.cap  <= cap_q;
      cell_q.side <= side_d_q;
      if (line_q) begin
        cell_q.num <= ACC_W'(sq) << SC;
        cell_q.den <= ACC_W'(c2l_q);
      end else begin
        cell_q.num <= ACC_W'(dh2_q) << SC;
        cell_q.den <= ACC_W'(1);
      end
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/aspb_root_cell.sv =====
// ----------------------------------------------------------------------------
// aspb_root_cell
// One cell of the root chain: settles one bit of floor(sqrt(num/den)) with
// shifts and adds on the running n*n*den and n*den.
// ----------------------------------------------------------------------------
module aspb_root_cell #(
  parameter int unsigned BIT_POS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  aspb_pkg::cell_t cell_i,
  output logic            valid_o,
  input  logic            ready_i,
  output aspb_pkg::cell_t cell_o
);
  import aspb_pkg::*;

  logic  valid_q;
  cell_t cell_q;
  cell_t cell_d;
  logic [ACC_W-1:0] s_try;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign cell_o  = cell_q;

  // (n + 2^k)^2 * den = s + t*2^(k+1) + den*2^2k
  assign s_try = cell_i.s + (cell_i.t << (BIT_POS + 1)) + (cell_i.den << (2 * BIT_POS));

  always_comb begin
    cell_d = cell_i;
    if (s_try <= cell_i.num) begin
      cell_d.n[BIT_POS] = 1'b1;
      cell_d.s          = s_try;
      cell_d.t          = cell_i.t + (cell_i.den << BIT_POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) cell_q <= cell_d;
  end

endmodule

// ===== rtl/aspb_blend.sv =====
// ----------------------------------------------------------------------------
// aspb_blend
// Coverage weight from radius and distance, then per-channel blend into the
// output register.
// ----------------------------------------------------------------------------
module aspb_blend #(
  parameter int unsigned RADIUS_FRAC_BITS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  aspb_pkg::cell_t cell_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [31:0]     new_pixel_o,
  output logic            touched_o
);
  import aspb_pkg::*;

  localparam logic signed [15:0] HALF = 16'sd1 <<< (RADIUS_FRAC_BITS - 1);
  localparam logic signed [15:0] ONE  = 16'sd1 <<< RADIUS_FRAC_BITS;

  logic rdy_1, rdy_2, v1_q, v2_q;

  assign rdy_2   = !v2_q || ready_i;
  assign rdy_1   = !v1_q || rdy_2;
  assign ready_o = rdy_1;
  assign valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy_1) v1_q <= valid_i;
      if (rdy_2) v2_q <= v1_q;
    end
  end

  // Stage 1: coverage and weight
  logic [ROOT_BITS-1:0] dist_val;
  logic signed [15:0]   rr, cov;
  logic [8:0]           a_d, a_q;
  logic                 tch_q;
  side_t                side_q;

  assign dist_val = cell_i.cap ? DIST_CAP : cell_i.n;
  assign rr       = (signed'({4'd0, cell_i.side.radius}) < HALF) ? HALF
                  : signed'({4'd0, cell_i.side.radius});
  assign cov      = rr + HALF - signed'({3'd0, dist_val});

  always_comb begin
    if (cov >= ONE) a_d = 9'd256;
    else            a_d = 9'(cov[8:0] << (8 - RADIUS_FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (rdy_1 && valid_i) begin
      a_q    <= a_d;
      tch_q  <= (cov > 16'sd0);
      side_q <= cell_i.side;
    end
  end

  // Stage 2: channel mix
  function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] p,
                                     input logic [8:0] a);
    logic [16:0] acc;
    acc = 17'(c) * 17'(a) + 17'(p) * (17'd256 - 17'(a));
    return acc[15:8];
  endfunction

  logic [31:0] blend;
  logic [31:0] pix_q;
  logic        touched_q;

  assign blend = {mix(8'hFF, side_q.dest[31:24], a_q),
                  mix(side_q.color[7:0], side_q.dest[23:16], a_q),
                  mix(side_q.color[15:8], side_q.dest[15:8], a_q),
                  mix(side_q.color[23:16], side_q.dest[7:0], a_q)};

  always_ff @(posedge clk_i) begin
    if (rdy_2 && v1_q) begin
      pix_q     <= tch_q ? blend : side_q.dest;
      touched_q <= tch_q;
    end
  end

  assign new_pixel_o = pix_q;
  assign touched_o   = touched_q;

endmodule

// ===== rtl/antialiased_segment_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// antialiased_segment_pixel_blend
// Anti-aliased capsule stroke coverage and blend, one pixel job per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one pixel job per transaction (position, segment, radius,
//   stroke colour, destination RGBA). Master stream: the blended pixel in
//   tdata and the touched flag in tuser, one transaction per job, in order.
//   The pipe is 20 register stages: five geometry stages, a chain of 13
//   root cells (one distance bit each) and two blend stages.
//   Throughput is one job per cycle while the receiver takes results; every
//   stage is a register with its own valid bit, so jobs follow back to back.
//   When the receiver stalls, the output holds and stages fill up behind
//   it; empty stages keep taking jobs, so tready falls only once the whole
//   pipe is full.
//   Reset clears all valid bits; nothing else is held between jobs.
// ----------------------------------------------------------------------------
module antialiased_segment_pixel_blend #(
  parameter int unsigned PIXEL_COORD_BITS = 12,
  parameter int unsigned RADIUS_FRAC_BITS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pixel_x, pixel_y, start_x, start_y, end_x, end_y, stroke_radius,
  // stroke_color, dest_pixel, zero fill
  input  logic [159:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // new_pixel
  output logic [31:0]  m_axis_tdata_o,
  // touched
  output logic         m_axis_tuser_o
);
  import aspb_pkg::*;

  side_t side_in;
  cell_t chain [0:ROOT_BITS];
  logic  chain_v [0:ROOT_BITS];
  logic  chain_r [0:ROOT_BITS];

  assign side_in.radius = s_axis_tdata_i[99:88];
  assign side_in.color  = s_axis_tdata_i[123:100];
  assign side_in.dest   = s_axis_tdata_i[155:124];

  // Geometry front end
  aspb_geom #(
    .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
    .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
  ) u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .pixel_x_i (s_axis_tdata_i[11:0]),
    .pixel_y_i (s_axis_tdata_i[23:12]),
    .start_x_i (s_axis_tdata_i[39:24]),
    .start_y_i (s_axis_tdata_i[55:40]),
    .end_x_i   (s_axis_tdata_i[71:56]),
    .end_y_i   (s_axis_tdata_i[87:72]),
    .side_i    (side_in),
    .valid_o   (chain_v[0]),
    .ready_i   (chain_r[0]),
    .cell_o    (chain[0])
  );

  // Root chain, most significant bit first
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    aspb_root_cell #(
      .BIT_POS (ROOT_BITS - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .ready_o (chain_r[k]),
      .cell_i  (chain[k]),
      .valid_o (chain_v[k+1]),
      .ready_i (chain_r[k+1]),
      .cell_o  (chain[k+1])
    );
  end

  // Coverage and blend
  aspb_blend #(
    .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_v[ROOT_BITS]),
    .ready_o     (chain_r[ROOT_BITS]),
    .cell_i      (chain[ROOT_BITS]),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .new_pixel_o (m_axis_tdata_o),
    .touched_o   (m_axis_tuser_o)
  );

endmodule

// ===== tb/antialiased_segment_pixel_blend_tb.sv =====
// ----------------------------------------------------------------------------
// antialiased_segment_pixel_blend_tb
// Self-checking bench: a table of directed pixel jobs then random jobs are
// streamed in; each blended pixel is compared, in order, with a typed-in
// result or a local capsule-coverage predictor, with random idling on both streams.
// ----------------------------------------------------------------------------
module antialiased_segment_pixel_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 4;
  localparam int unsigned LATENCY    = 20;
  localparam int unsigned N_RANDOM   = 1400;
  localparam longint      CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [31:0] dest;
    logic [23:0] color;
    logic [11:0] radius;
    logic [15:0] ey;
    logic [15:0] ex;
    logic [15:0] sy;
    logic [15:0] sx;
    logic [11:0] py;
    logic [11:0] px;
  } job_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        touched;
  } blend_t;

  // Directed row: job, and an optional typed-in result
  typedef struct {
    job_t   job;
    bit     fixed;
    blend_t res;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [31:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;

  blend_t  pending_q[$];
  int      mismatches;
  bit      hold_long;
  longint  cycle_cnt;

  antialiased_segment_pixel_blend DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Largest n below 8192 with n*n*den <= num
  function automatic longint unsigned isqrt_ratio(longint unsigned num,
                                                  longint unsigned den);
    longint unsigned n;
    longint unsigned cand;
    n = 0;
    for (int b = 12; b >= 0; b--) begin
      cand = n | (64'd1 << b);
      if (cand * cand * den <= num) n = cand;
    end
    return n;
  endfunction

  function automatic logic [7:0] mix_channel(longint unsigned c, longint unsigned p,
                                             longint unsigned a);
    return 8'((c * a + p * (256 - a)) >> 8);
  endfunction

  // Capsule coverage and blend, coordinates in half pixels
  function automatic blend_t predict_blend(job_t j);
    longint          px, py, ax, ay, bx, by, vx, vy, wx, wy, c1, c2, cr, r, hf, cov;
    longint          dx, dy;
    longint unsigned d, ac, a;
    int unsigned     sc;
    blend_t          o;
    sc = 2 * FRAC_BITS - 2;
    hf = 1 << (FRAC_BITS - 1);
    px = 2 * longint'(j.px[COORD_BITS-1:0]) + 1;
    py = 2 * longint'(j.py[COORD_BITS-1:0]) + 1;
    ax = 2 * longint'($signed(j.sx));
    ay = 2 * longint'($signed(j.sy));
    bx = 2 * longint'($signed(j.ex));
    by = 2 * longint'($signed(j.ey));
    vx = bx - ax; vy = by - ay; wx = px - ax; wy = py - ay;
    c1 = vx * wx + vy * wy;
    c2 = vx * vx + vy * vy;
    if (c1 <= 0) begin
      d = isqrt_ratio(longint'(wx * wx + wy * wy) << sc, 1);
    end else if (c2 <= c1) begin
      dx = px - bx; dy = py - by;
      d = isqrt_ratio(longint'(dx * dx + dy * dy) << sc, 1);
    end else begin
      cr = vx * wy - vy * wx;
      ac = (cr < 0) ? -cr : cr;
      if (ac >= (64'd1 << (32 - FRAC_BITS))) d = 8191;
      else d = isqrt_ratio((ac * ac) << sc, c2);
    end
    r = j.radius;
    if (r < hf) r = hf;
    cov = r + hf - longint'(d);
    if (cov <= 0) begin
      o.pixel = j.dest;
      o.touched = 1'b0;
    end else begin
      a = longint'(cov) << (8 - FRAC_BITS);
      if (a > 256) a = 256;
      o.pixel[7:0]   = mix_channel(j.color[23:16], j.dest[7:0], a);
      o.pixel[15:8]  = mix_channel(j.color[15:8], j.dest[15:8], a);
      o.pixel[23:16] = mix_channel(j.color[7:0], j.dest[23:16], a);
      o.pixel[31:24] = mix_channel(255, j.dest[31:24], a);
      o.touched = 1'b1;
    end
    return o;
  endfunction

  function automatic job_t mk_job(int x, int y, int sx, int sy, int ex, int ey,
                                  int rad, logic [23:0] col, logic [31:0] dst);
    job_t j;
    j.px = 12'(x); j.py = 12'(y);
    j.sx = 16'(sx); j.sy = 16'(sy); j.ex = 16'(ex); j.ey = 16'(ey);
    j.radius = 12'(rad); j.color = col; j.dest = dst;
    return j;
  endfunction

  // Random job, mostly near the segment so coverage varies
  function automatic job_t rand_job();
    job_t j;
    int   bx, by;
    j = job_t'(156'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(0, 9) < 7) begin
      bx = $urandom_range(0, 4095);
      by = $urandom_range(0, 4095);
      j.px = 12'(bx); j.py = 12'(by);
      j.sx = 16'(bx + $signed($urandom_range(0, 40)) - 20);
      j.sy = 16'(by + $signed($urandom_range(0, 40)) - 20);
      if ($urandom_range(0, 7) == 0) begin
        j.ex = j.sx; j.ey = j.sy;
      end else begin
        j.ex = 16'(bx + $signed($urandom_range(0, 60)) - 30);
        j.ey = 16'(by + $signed($urandom_range(0, 60)) - 30);
      end
      if ($urandom_range(0, 3) != 0) j.radius = 12'($urandom_range(0, 200));
    end
    return j;
  endfunction

  // Offer one job and wait for its acceptance
  task automatic send_job(job_t j);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= 160'(j);
    pending_q.push_back(predict_blend(j));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Receiver readiness: random stalls, one long hold-off
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        m_axis_tready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_long = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    blend_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata_o);
      end else begin
        want = pending_q.pop_front();
        if (want.pixel !== m_axis_tdata_o || want.touched !== m_axis_tuser_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pixel %h touched %b, got %h %b",
                     want.pixel, want.touched, m_axis_tdata_o, m_axis_tuser_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    mismatches = 0;
    hold_long = 1'b0;
    cycle_cnt = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: full cover, no cover, small radius, dot, extremes
    rw.fixed = 1'b1;
    rw.job = mk_job(10, 10, 10, 10, 10, 10, 32, 24'h123456, 32'h00000000);
    rw.res = '{pixel: 32'hFF563412, touched: 1'b1}; rows.push_back(rw);
    rw.job = mk_job(100, 100, 0, 0, 0, 0, 16, 24'hFFFFFF, 32'hDEADBEEF);
    rw.res = '{pixel: 32'hDEADBEEF, touched: 1'b0}; rows.push_back(rw);
    rw.job = mk_job(4095, 4095, -32768, -32768, 32767, -32768, 4095, 24'hFFFFFF,
                    32'h01020304);
    rw.res = '{pixel: 32'h01020304, touched: 1'b0}; rows.push_back(rw);
    rw.job = mk_job(0, 0, 0, 0, 0, 0, 4095, 24'hABCDEF, 32'h00000000);
    rw.res = '{pixel: 32'hFFEFCDAB, touched: 1'b1}; rows.push_back(rw);
    rw.fixed = 1'b0;
    rw.job = mk_job(5, 5, 5, 5, 5, 5, 0, 24'hFFFFFF, 32'h00000000); rows.push_back(rw);
    rw.job = mk_job(5, 6, 0, 6, 20, 6, 3, 24'h00FF00, 32'h80808080); rows.push_back(rw);
    rw.job = mk_job(5, 7, 0, 6, 20, 6, 8, 24'hFF0000, 32'hFFFFFFFF); rows.push_back(rw);
    rw.job = mk_job(25, 6, 0, 6, 20, 6, 60, 24'h0000FF, 32'h11223344); rows.push_back(rw);
    rw.job = mk_job(0, 0, 3, 3, -3, -3, 10, 24'h808080, 32'h7F7F7F7F); rows.push_back(rw);
    rw.job = mk_job(4095, 0, 4090, 4, 4100, -6, 20, 24'hFFFFFF, 32'hFFFFFFFF);
    rows.push_back(rw);
    rw.job = mk_job(0, 4095, -32768, 32767, 32767, -32768, 100, 24'h000000,
                    32'hFFFFFFFF); rows.push_back(rw);
    rw.job = mk_job(2048, 2048, 32767, 32767, -32768, -32768, 4095, 24'h5A5A5A,
                    32'hA5A5A5A5); rows.push_back(rw);
    rw.job = mk_job(7, 3, 0, 0, 14, 7, 1, 24'hC0FFEE, 32'h00FF00FF); rows.push_back(rw);

    foreach (rows[i]) begin
      send_job(rows[i].job);
      if (rows[i].fixed) pending_q[pending_q.size()-1] = rows[i].res;
    end

    // Random jobs; one long receiver hold-off, one full drain pause
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_long = 1'b1;
      if (n == 800) begin
        s_axis_tvalid_i <= 1'b0;
        wait (pending_q.size() == 0);
      end
      send_job(rand_job());
    end
    s_axis_tvalid_i <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
